@@ rtl/mdrpm_pkg.sv @@
package mdrpm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int LEVEL_W     = 16;
    localparam int COUNT_OUT_W = 13;
    localparam int CFG_W       = 3;
    localparam int LANES       = 4;
    localparam int MIX_W       = SAMPLE_W + 2;
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 17;
    localparam int ROOT_W      = 16;
    localparam int RAD_W       = 2 * ROOT_W;
    localparam int SQ_W        = 2 * LEVEL_W;

    localparam int DEF_CHANNELS  = 4;
    localparam int DEF_MAX_BLOCK = 4096;

    localparam logic [CFG_W-1:0] CFG_CHANS_RESET = CFG_W'(1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_ch0;
        logic signed [SAMPLE_W-1:0] sample_ch1;
        logic signed [SAMPLE_W-1:0] sample_ch2;
        logic signed [SAMPLE_W-1:0] sample_ch3;
        logic                       last_frame;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mono_sample;
        logic                       block_done;
        logic [LEVEL_W-1:0]         rms_level;
        logic [LEVEL_W-1:0]         peak_level;
        logic [COUNT_OUT_W-1:0]     block_samples;
    } t_out;

    // Reciprocal of the channel count, scaled by 2^RECIP_SHIFT. Exact for
    // counts 1, 2 and 4; for 3 the floor stays exact below 2^17.
    function automatic logic [RECIP_W-1:0] mix_recip(input logic [CFG_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            CFG_W'(1): r = RECIP_W'(131072);
            CFG_W'(2): r = RECIP_W'(65536);
            CFG_W'(3): r = RECIP_W'(43691);
            CFG_W'(4): r = RECIP_W'(32768);
            default:   r = RECIP_W'(131072);
        endcase
        return r;
    endfunction

endpackage

@@ rtl/mono_downmix_rms_peak_meter_core.sv @@
// Mono downmix with block RMS and peak meter.
//
// Input channel: one frame per request (four Q1.15 samples and a last-frame
// mark) on i_in_valid / o_in_stall. Output channel: one result per frame on
// o_out_valid / i_out_stall, carrying the mono average and, on the frame that
// closes a block, the RMS level, peak level and frame count.
// i_cfg_we / i_cfg_wdata set the number of channels averaged (0 reads as 1,
// values above the channel limit are clamped).
//
// A frame runs through a small sequencer: mix, scale, square, accumulate and
// emit; the input stalls from the accept until the result is emitted. A frame
// that closes a block also runs a division and a square root: one shared
// subtractor computes the mean square one quotient bit a cycle and then its
// root one bit a cycle.
// The result sits in an output register, so the next frame is accepted while
// a stalled result waits; the sequencer holds in its emit step until the
// register is free. Reset clears the accumulators, the output valid and sets
// the channel count to 1.
module mono_downmix_rms_peak_meter_core #(
    parameter int CHANNELS  = mdrpm_pkg::DEF_CHANNELS,
    parameter int MAX_BLOCK = mdrpm_pkg::DEF_MAX_BLOCK
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  mdrpm_pkg::t_in               i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output mdrpm_pkg::t_out              o_out_data,
    input  logic                         i_cfg_we,
    input  logic [mdrpm_pkg::CFG_W-1:0]  i_cfg_wdata
);

    localparam int CFG_W   = mdrpm_pkg::CFG_W;
    localparam int MIX_W   = mdrpm_pkg::MIX_W;
    localparam int LEVEL_W = mdrpm_pkg::LEVEL_W;
    localparam int ROOT_W  = mdrpm_pkg::ROOT_W;
    localparam int RAD_W   = mdrpm_pkg::RAD_W;
    localparam int SQ_W    = mdrpm_pkg::SQ_W;
    localparam int RECIP_W = mdrpm_pkg::RECIP_W;
    localparam int LANES   = mdrpm_pkg::LANES;
    localparam int LIMIT   = (CHANNELS < LANES) ? CHANNELS : LANES;
    localparam int CNT_W   = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W   = $clog2(MAX_BLOCK) + SQ_W - 1;
    localparam int U_W     = (CNT_W + 1 > ROOT_W + 2) ? CNT_W + 1 : ROOT_W + 2;
    localparam int STEP_W  = $clog2(SUM_W);
    localparam int PROD_W  = MIX_W + RECIP_W;

    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_BLOCK);
    localparam logic [CFG_W-1:0] LIMIT_CNT = CFG_W'(LIMIT);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MIX    = 7'b0000010,
        S_SCALE  = 7'b0000100,
        S_SQUARE = 7'b0001000,
        S_ACCUM  = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_ROOT   = 7'b1000000
    } t_state_core;

    // Emit is folded into a separate flag so the state set stays small.
    t_state_core r_state, n_state;
    logic        r_emit, n_emit;

    logic [CFG_W-1:0] r_chans;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [LEVEL_W-1:0] r_peak, n_peak;
    logic [CNT_W-1:0] r_count, n_count;
    logic r_out_valid, n_out_valid;

    mdrpm_pkg::t_in  r_in;
    mdrpm_pkg::t_out r_out, n_out;
    logic [CFG_W-1:0] r_n, n_n;
    logic [MIX_W-1:0] r_abs, n_abs;
    logic r_neg, n_neg;
    logic [LEVEL_W-1:0] r_mag, n_mag;
    logic [SQ_W-1:0] r_sq, n_sq;
    logic r_done, n_done;
    logic [SUM_W-1:0] r_acc, n_acc;
    logic [U_W-1:0] r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [STEP_W-1:0] r_step, n_step;

    // Shared subtract/compare unit
    logic [U_W-1:0] u_a, u_b;
    logic [U_W:0]   u_diff;
    logic           u_ge;

    logic signed [mdrpm_pkg::SAMPLE_W-1:0] lane [LANES];
    logic signed [MIX_W-1:0] mix_total;
    logic [CFG_W-1:0] n_eff;
    logic [PROD_W-1:0] scale_prod;
    logic [LEVEL_W:0] mono_ext;
    logic out_free;

    assign lane[0] = r_in.sample_ch0;
    assign lane[1] = r_in.sample_ch1;
    assign lane[2] = r_in.sample_ch2;
    assign lane[3] = r_in.sample_ch3;

    always_comb begin
        if (r_chans == CFG_W'(0)) begin
            n_eff = CFG_W'(1);
        end else if (r_chans > LIMIT_CNT) begin
            n_eff = LIMIT_CNT;
        end else begin
            n_eff = r_chans;
        end
    end

    always_comb begin
        mix_total = '0;
        for (int i = 0; i < LANES; i++) begin
            if (CFG_W'(i) < n_eff) begin
                mix_total = mix_total + MIX_W'(lane[i]);
            end
        end
    end

    assign scale_prod = PROD_W'(r_abs) * PROD_W'(mdrpm_pkg::mix_recip(r_n));
    assign mono_ext   = r_neg ? ((LEVEL_W + 1)'(0) - {1'b0, r_mag}) : {1'b0, r_mag};
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        case (r_state)
            S_DIV: begin
                u_a = U_W'({r_rem[CNT_W-1:0], r_acc[SUM_W-1]});
                u_b = U_W'(r_count);
            end
            S_ROOT: begin
                u_a = {r_rem[U_W-3:0], r_acc[RAD_W-1 -: 2]};
                u_b = U_W'({r_root, 2'b01});
            end
            default: begin
                u_a = '0;
                u_b = '0;
            end
        endcase
        u_diff = {1'b0, u_a} - {1'b0, u_b};
        u_ge   = !u_diff[U_W];
    end

    always_comb begin
        n_state     = r_state;
        n_emit      = r_emit;
        n_sum       = r_sum;
        n_peak      = r_peak;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_n         = r_n;
        n_abs       = r_abs;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_sq        = r_sq;
        n_done      = r_done;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_root      = r_root;
        n_step      = r_step;

        // Drop the output once taken.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (r_emit) begin
                    if (out_free) begin
                        n_out.mono_sample = mono_ext[LEVEL_W-1:0];
                        n_out.block_done  = r_done;
                        if (r_done) begin
                            n_out.rms_level     = r_root;
                            n_out.peak_level    = r_peak;
                            n_out.block_samples = mdrpm_pkg::COUNT_OUT_W'(r_count);
                            n_sum   = '0;
                            n_peak  = '0;
                            n_count = '0;
                        end else begin
                            n_out.rms_level     = '0;
                            n_out.peak_level    = '0;
                            n_out.block_samples = '0;
                        end
                        n_out_valid = 1'b1;
                        n_emit      = 1'b0;
                    end
                end else if (i_in_valid) begin
                    n_state = S_MIX;
                end
            end
            S_MIX: begin
                n_n     = n_eff;
                n_neg   = mix_total[MIX_W-1];
                n_abs   = mix_total[MIX_W-1] ? (MIX_W'(0) - MIX_W'(mix_total))
                                             : MIX_W'(mix_total);
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_mag   = LEVEL_W'(scale_prod >> mdrpm_pkg::RECIP_SHIFT);
                n_state = S_SQUARE;
            end
            S_SQUARE: begin
                n_sq    = SQ_W'(r_mag) * SQ_W'(r_mag);
                if (r_mag > r_peak) begin
                    n_peak = r_mag;
                end
                n_count = r_count + CNT_W'(1);
                n_state = S_ACCUM;
            end
            S_ACCUM: begin
                n_sum  = r_sum + SUM_W'(r_sq);
                n_done = r_in.last_frame || (r_count >= MAX_CNT);
                if (r_in.last_frame || (r_count >= MAX_CNT)) begin
                    n_acc   = r_sum + SUM_W'(r_sq);
                    n_rem   = '0;
                    n_step  = STEP_W'(SUM_W - 1);
                    n_state = S_DIV;
                end else begin
                    n_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                // Restoring division: shift the sum out, the quotient in.
                n_rem = u_ge ? u_diff[U_W-1:0] : u_a;
                n_acc = {r_acc[SUM_W-2:0], u_ge};
                if (r_step == STEP_W'(0)) begin
                    n_rem   = '0;
                    n_root  = '0;
                    n_step  = STEP_W'(ROOT_W - 1);
                    n_state = S_ROOT;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            S_ROOT: begin
                // Take two radicand bits per step, one root bit out.
                n_rem  = u_ge ? u_diff[U_W-1:0] : u_a;
                n_root = {r_root[ROOT_W-2:0], u_ge};
                n_acc  = {r_acc[SUM_W-3:0], 2'b00};
                if (r_step == STEP_W'(0)) begin
                    n_emit  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE) || r_emit;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_emit      <= 1'b0;
            r_chans     <= mdrpm_pkg::CFG_CHANS_RESET;
            r_sum       <= '0;
            r_peak      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_emit      <= n_emit;
            r_sum       <= n_sum;
            r_peak      <= n_peak;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_chans <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
        r_out  <= n_out;
        r_n    <= n_n;
        r_abs  <= n_abs;
        r_neg  <= n_neg;
        r_mag  <= n_mag;
        r_sq   <= n_sq;
        r_done <= n_done;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_step <= n_step;
    end

    a_quiet_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.block_done) |->
        (o_out_data.rms_level == '0 && o_out_data.peak_level == '0 &&
         o_out_data.block_samples == '0))
        else $error("level fields set on a frame that did not close a block");

    a_rms_below_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.block_done) |->
        (o_out_data.rms_level <= o_out_data.peak_level))
        else $error("rms level above peak level");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_ROOT) |-> (r_count != '0))
        else $error("mean square taken over an empty block");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_MIX))
        else $error("accepted request did not start the sequencer");

endmodule

@@ bench/mono_downmix_rms_peak_meter_checker.sv @@
module mono_downmix_rms_peak_meter_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  mdrpm_pkg::t_in              i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  mdrpm_pkg::t_out             i_out_data,
    input  logic                        i_cfg_we,
    input  logic [mdrpm_pkg::CFG_W-1:0] i_cfg_wdata,
    output int                          o_mismatches,
    output int                          o_pending,
    output int                          o_blocks
);

    localparam int CFG_W         = mdrpm_pkg::CFG_W;
    localparam int SAMPLE_W      = mdrpm_pkg::SAMPLE_W;
    localparam int LEVEL_W       = mdrpm_pkg::LEVEL_W;
    localparam int COUNT_OUT_W   = mdrpm_pkg::COUNT_OUT_W;
    localparam int LANES         = mdrpm_pkg::LANES;
    localparam int DEF_MAX_BLOCK = mdrpm_pkg::DEF_MAX_BLOCK;
    localparam int CHAN_LIMIT    = (mdrpm_pkg::DEF_CHANNELS < LANES) ?
                                   mdrpm_pkg::DEF_CHANNELS : LANES;
    localparam int MAX_REPORTS   = 10;

    logic [CFG_W-1:0] chans_reg;
    longint unsigned  energy_sum;
    int unsigned      peak_mag;
    int unsigned      frames;
    int               mismatch_count;
    int               block_count;
    mdrpm_pkg::t_out  downmix_q[$];

    function automatic int unsigned floor_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 20; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root[31:0];
    endfunction

    // Downmix one frame, fold it into the block meter and queue the result word.
    task automatic mix_and_meter(input mdrpm_pkg::t_in f);
        logic signed [SAMPLE_W-1:0] lane [LANES];
        int              n;
        int              total;
        int              mono;
        int unsigned     mag;
        mdrpm_pkg::t_out word;
        lane[0] = f.sample_ch0;
        lane[1] = f.sample_ch1;
        lane[2] = f.sample_ch2;
        lane[3] = f.sample_ch3;
        n = int'(chans_reg);
        if (n == 0)
            n = 1;
        if (n > CHAN_LIMIT)
            n = CHAN_LIMIT;
        total = 0;
        for (int i = 0; i < n; i++)
            total += int'(lane[i]);
        // integer division truncates toward zero
        mono = total / n;
        mag = (mono < 0) ? -mono : mono;
        energy_sum += 64'(mag) * 64'(mag);
        if (mag > peak_mag)
            peak_mag = mag;
        frames++;
        word = '0;
        word.mono_sample = SAMPLE_W'(mono);
        if (f.last_frame || frames >= DEF_MAX_BLOCK) begin
            word.block_done = 1'b1;
            word.rms_level = LEVEL_W'(floor_sqrt(energy_sum / frames));
            word.peak_level = LEVEL_W'(peak_mag);
            word.block_samples = COUNT_OUT_W'(frames);
            energy_sum = 0;
            peak_mag = 0;
            frames = 0;
            block_count++;
        end
        downmix_q.insert(downmix_q.size(), word);
    endtask

    task automatic compare_result(input mdrpm_pkg::t_out got);
        mdrpm_pkg::t_out want;
        logic bad;
        if (downmix_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("unexpected result: mono %0d done %0b rms %0d peak %0d count %0d",
                         got.mono_sample, got.block_done, got.rms_level,
                         got.peak_level, got.block_samples);
            return;
        end
        want = downmix_q.pop_front();
        bad = (got.mono_sample !== want.mono_sample)
            || (got.block_done !== want.block_done)
            || (got.rms_level !== want.rms_level)
            || (got.peak_level !== want.peak_level)
            || (got.block_samples !== want.block_samples);
        if (bad) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("mismatch (exp/got): mono %0d/%0d done %0b/%0b rms %0d/%0d %s",
                         want.mono_sample, got.mono_sample, want.block_done,
                         got.block_done, want.rms_level, got.rms_level,
                         $sformatf("peak %0d/%0d count %0d/%0d", want.peak_level,
                                   got.peak_level, want.block_samples,
                                   got.block_samples));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chans_reg = mdrpm_pkg::CFG_CHANS_RESET;
            energy_sum = 0;
            peak_mag = 0;
            frames = 0;
            mismatch_count = 0;
            block_count = 0;
            downmix_q.delete();
        end else begin
            // check the departing result before queuing the new request
            if (i_out_valid && !i_out_stall)
                compare_result(i_out_data);
            if (i_in_valid && !i_in_stall)
                mix_and_meter(i_in_data);
            if (i_cfg_we)
                chans_reg = i_cfg_wdata;
        end
        o_mismatches <= mismatch_count;
        o_pending <= downmix_q.size();
        o_blocks <= block_count;
    end

endmodule

@@ bench/mono_downmix_rms_peak_meter_core_tb.sv @@
module mono_downmix_rms_peak_meter_core_tb;

    localparam int CFG_W         = mdrpm_pkg::CFG_W;
    localparam int SAMPLE_W      = mdrpm_pkg::SAMPLE_W;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_FRAMES  = 50;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    mdrpm_pkg::t_in   in_data = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    mdrpm_pkg::t_out  out_data;
    logic             cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    int mismatches;
    int pending;
    int blocks;
    int cycles = 0;
    int stall_left = 0;
    int frames_sent = 0;
    bit gaps_on = 1'b1;
    bit stall_on = 1'b1;

    mono_downmix_rms_peak_meter_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    mono_downmix_rms_peak_meter_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_blocks     (blocks)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // mostly short spans, now and then a long one
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (stall_on && !out_stall) begin
            out_stall <= 1'b1;
            stall_left <= idle_span();
        end else begin
            out_stall <= 1'b0;
            stall_left <= stall_on ? idle_span() : 0;
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return SAMPLE_W'(-32768);
        if (r == 1)
            return SAMPLE_W'(32767);
        if (r == 2)
            return SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
        return SAMPLE_W'($urandom);
    endfunction

    function automatic mdrpm_pkg::t_in random_frame(input bit last);
        mdrpm_pkg::t_in f;
        f.sample_ch0 = random_sample();
        f.sample_ch1 = random_sample();
        f.sample_ch2 = random_sample();
        f.sample_ch3 = random_sample();
        f.last_frame = last;
        return f;
    endfunction

    task automatic send_frame(input mdrpm_pkg::t_in f);
        int gap;
        gap = gaps_on ? idle_span() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= f;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        frames_sent++;
    endtask

    task automatic send_mix(input int a, input int b, input int c, input int d, input bit last);
        mdrpm_pkg::t_in f;
        f.sample_ch0 = SAMPLE_W'(a);
        f.sample_ch1 = SAMPLE_W'(b);
        f.sample_ch2 = SAMPLE_W'(c);
        f.sample_ch3 = SAMPLE_W'(d);
        f.last_frame = last;
        send_frame(f);
    endtask

    // drop valid, drain every pending result, then write the channel count
    task automatic write_chans(input logic [CFG_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    logic [CFG_W-1:0] phase_chans [8] = '{3'd5, 3'd6, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd7};

    initial begin
        int run_left;
        int r;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset channel count of one
        send_mix(32767, -32768, 5, -5, 1'b0);
        send_mix(-32768, 32767, 0, 0, 1'b1);
        // zero reads as one channel; an all-zero single-frame block
        write_chans(3'd0);
        send_mix(-1, 100, 100, 100, 1'b1);
        send_mix(0, 0, 0, 0, 1'b1);
        // two channels: negative averages truncate toward zero
        write_chans(3'd2);
        send_mix(-32768, -32768, 7, 7, 1'b0);
        send_mix(32767, -32768, 0, 0, 1'b0);
        send_mix(3, -4, 0, 0, 1'b0);
        send_mix(-3, 0, 0, 0, 1'b1);
        write_chans(3'd3);
        send_mix(1, 1, 0, 9, 1'b0);
        send_mix(-32768, -32768, -32768, 1, 1'b0);
        send_mix(32767, 32767, 32767, 0, 1'b0);
        send_mix(-1, -1, 0, 0, 1'b0);
        send_mix(5, 0, 0, 0, 1'b1);
        write_chans(3'd4);
        send_mix(-32768, -32768, -32768, -32768, 1'b0);
        send_mix(32767, 32767, 32767, 32767, 1'b0);
        send_mix(1, 1, 1, -4, 1'b0);
        send_mix(-7, 0, 0, 0, 1'b1);
        // above the channel limit clamps to four
        write_chans(3'd7);
        send_mix(-32768, -32768, -32768, -32768, 1'b1);
        send_mix(1, 2, 3, 4, 1'b1);

        // random blocks, mostly short; blocks may straddle a channel change
        run_left = 0;
        foreach (phase_chans[p]) begin
            write_chans(phase_chans[p]);
            gaps_on = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_FRAMES; i++) begin
                if (run_left == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        run_left = $urandom_range(1, 6);
                    else if (r < 95)
                        run_left = $urandom_range(7, 30);
                    else
                        run_left = $urandom_range(31, 120);
                end
                send_frame(random_frame(run_left == 1));
                run_left--;
            end
        end

        // close any open block, then a short block with gaps and stalls
        send_frame(random_frame(1'b1));
        write_chans(3'd1);
        gaps_on = 1'b1;
        stall_on = 1'b1;
        send_frame(random_frame(1'b0));
        send_frame(random_frame(1'b0));
        send_frame(random_frame(1'b1));

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d frames in %0d closed blocks, channel counts 0 through 7,",
                 frames_sent, blocks);
        $display("with full-scale samples, random input gaps and output stalls");
        if (mismatches == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/mdrpm_pkg.sv
rtl/mono_downmix_rms_peak_meter_core.sv
bench/mono_downmix_rms_peak_meter_checker.sv
bench/mono_downmix_rms_peak_meter_core_tb.sv
